/* rtl/euv_pkg.sv */
// ---------------------------------------------------------------------------
// euv_pkg: shared types and constants for the encoder unwrap block
// Field widths, speed and angle scale factors, controller states and the
// command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package euv_pkg;

   // sensor and speed format
   localparam int COUNTS_PER_REV  = 4096;
   localparam int SPEED_FRAC_BITS = 8;

   // field widths
   localparam int ANGLE_W = $clog2(COUNTS_PER_REV);
   localparam int DELTA_W = ANGLE_W + 1;
   localparam int TOTAL_W = 32;
   localparam int RPM_W   = 28;
   localparam int RAD_W   = 25;
   localparam int ANG_W   = 40;
   localparam int DT_W    = 20;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DT_W;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT       = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL = CSR_IDX_W'(1);
   localparam logic [DT_W-1:0]      MIN_INTERVAL_RST = DT_W'(100);

   // unwrap arithmetic
   localparam int DIFF_W    = ANGLE_W + 2;
   localparam int HALF_TURN = COUNTS_PER_REV / 2;

   // rpm per count-per-microsecond, in speed fraction bits
   localparam longint unsigned SPEED_SCALE =
      (64'd60000000 << SPEED_FRAC_BITS) / COUNTS_PER_REV;
   localparam int SCALE_W = $clog2(SPEED_SCALE + 1);
   localparam int MAG_W   = DELTA_W - 1;
   localparam int NUM_W   = MAG_W + SCALE_W;
   localparam int CNT_W   = $clog2(NUM_W);

   // speed smoothing weights over 256
   localparam int EMA_SHIFT = 8;
   localparam int SUM_W     = RPM_W + 10;
   localparam logic signed [9:0] W_NEW = 10'sd77;
   localparam logic signed [9:0] W_OLD = 10'sd179;

   // 2*pi in Q32 and derived output scale factors
   localparam longint unsigned TWO_PI_Q32 = 64'd26986075409;
   localparam longint unsigned KRAD       = TWO_PI_Q32 / 60;
   localparam longint unsigned KANG       = TWO_PI_Q32 / COUNTS_PER_REV;
   localparam int KRAD_W    = $clog2(KRAD + 1);
   localparam int KANG_W    = $clog2(KANG + 1);
   localparam int RAD_P_W   = RPM_W + KRAD_W + 1;
   localparam int ANG_P_W   = TOTAL_W + KANG_W + 1;
   localparam int RAD_SHIFT = 32;
   localparam int ANG_SHIFT = 16;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_DIVIDE,
      ST_SATURATE,
      ST_SMOOTH,
      ST_SCALE,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic update;
      logic div_load;
      logic div_step;
      logic saturate;
      logic smooth;
      logic scale;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic speed_go;
   } status_type;

endpackage

`default_nettype wire

/* rtl/euv_ifs.sv */
// ---------------------------------------------------------------------------
// euv channel interfaces
// Valid/ready channels for samples, results and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface euv_req_if;
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [euv_pkg::ANGLE_W-1:0]  raw_angle;
   logic [euv_pkg::DT_W-1:0]     interval_us;

   modport source (output valid, func, raw_angle, interval_us, input ready);
   modport sink   (input valid, func, raw_angle, interval_us, output ready);
endinterface

interface euv_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [euv_pkg::ANGLE_W-1:0]         angle_now;
   logic signed [euv_pkg::DELTA_W-1:0]  delta_steps;
   logic signed [euv_pkg::TOTAL_W-1:0]  total_steps;
   logic signed [euv_pkg::RPM_W-1:0]    speed_rpm_q8;
   logic signed [euv_pkg::RAD_W-1:0]    speed_rad_q8;
   logic signed [euv_pkg::ANG_W-1:0]    angle_rad_q16;
   logic                                primed;

   modport source (output valid, angle_now, delta_steps, total_steps, speed_rpm_q8,
                   speed_rad_q8, angle_rad_q16, primed, input ready);
   modport sink   (input valid, angle_now, delta_steps, total_steps, speed_rpm_q8,
                   speed_rad_q8, angle_rad_q16, primed, output ready);
endinterface

interface euv_csr_if;
   logic                             valid;
   logic                             ready;
   logic [euv_pkg::CSR_IDX_W-1:0]    index;
   logic [euv_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/encoder_unwrap_velocity.sv */
// A sample transaction is captured and unwrapped; when speed is refreshed it then
// passes the restoring divider (one quotient bit per cycle), saturation and smoothing
// before scaling, otherwise it goes straight to scaling. A new sample is taken only
// once the previous one is in the output register. A result waiting in the output
// register does not block the next sample. Reset is synchronous: state zero,
// not primed, invert 0, minimum interval 100 us.
// ---------------------------------------------------------------------------
// encoder_unwrap_velocity: absolute angle unwrap with smoothed speed
// Unwraps 12-bit angle samples into a wrapping step total and derives a
// smoothed speed in rpm and rad/s plus the total angle in radians.
// ---------------------------------------------------------------------------
`default_nettype none

module encoder_unwrap_velocity (
   input  wire logic  clock,
   input  wire logic  reset,
   euv_req_if.sink    req_ch,
   euv_rsp_if.source  rsp_ch,
   euv_csr_if.sink    csr_ch
);
   import euv_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;

   // register writes always taken
   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

   // sequencer
   euv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic and state
   euv_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_ch.func),
      .req_raw_angle     (req_ch.raw_angle),
      .req_interval_us   (req_ch.interval_us),
      .csr_write         (csr_ch.valid),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .rsp_angle_now     (rsp_ch.angle_now),
      .rsp_delta_steps   (rsp_ch.delta_steps),
      .rsp_total_steps   (rsp_ch.total_steps),
      .rsp_speed_rpm_q8  (rsp_ch.speed_rpm_q8),
      .rsp_speed_rad_q8  (rsp_ch.speed_rad_q8),
      .rsp_angle_rad_q16 (rsp_ch.angle_rad_q16),
      .rsp_primed        (rsp_ch.primed)
   );

endmodule

`default_nettype wire

/* rtl/euv_ctrl.sv */
// ---------------------------------------------------------------------------
// euv_ctrl: sequencer for the encoder unwrap block
// Walks each sample through update and scaling, with divide, saturation and
// smoothing when speed is refreshed, and owns the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module euv_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output euv_pkg::cmd_type         cmd,
   input  wire euv_pkg::status_type status
);
   import euv_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   // output register may be refilled when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   // state, divide counter and result flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.speed_go ? ST_LOAD : ST_SCALE;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = ST_SATURATE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SATURATE: begin
            cmd.saturate = 1'b1;
            state_in     = ST_SMOOTH;
         end
         ST_SMOOTH: begin
            cmd.smooth = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result flag: set on load, cleared when taken
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/euv_dpath.sv */
// ---------------------------------------------------------------------------
// euv_dpath: datapath for the encoder unwrap block
// Angle unwrap, step total, restoring divider for instantaneous speed,
// smoothing filter, output scaling and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module euv_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire euv_pkg::cmd_type                    cmd,
   output euv_pkg::status_type                      status,
   input  wire logic                                req_func,
   input  wire logic [euv_pkg::ANGLE_W-1:0]         req_raw_angle,
   input  wire logic [euv_pkg::DT_W-1:0]            req_interval_us,
   input  wire logic                                csr_write,
   input  wire logic [euv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [euv_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic [euv_pkg::ANGLE_W-1:0]              rsp_angle_now,
   output logic signed [euv_pkg::DELTA_W-1:0]       rsp_delta_steps,
   output logic signed [euv_pkg::TOTAL_W-1:0]       rsp_total_steps,
   output logic signed [euv_pkg::RPM_W-1:0]         rsp_speed_rpm_q8,
   output logic signed [euv_pkg::RAD_W-1:0]         rsp_speed_rad_q8,
   output logic signed [euv_pkg::ANG_W-1:0]         rsp_angle_rad_q16,
   output logic                                     rsp_primed
);
   import euv_pkg::*;

   localparam logic signed [DIFF_W-1:0]  HALF_S   = DIFF_W'(HALF_TURN);
   localparam logic signed [DIFF_W-1:0]  REV_S    = DIFF_W'(COUNTS_PER_REV);
   localparam logic [NUM_W-1:0]          SCALE_C  = NUM_W'(SPEED_SCALE);
   localparam logic [NUM_W-1:0]          RPM_MAX_U = NUM_W'((64'd1 << (RPM_W - 1)) - 1);
   localparam logic signed [RPM_W-1:0]   RPM_MAX_S = RPM_W'((64'd1 << (RPM_W - 1)) - 1);
   localparam logic signed [RPM_W-1:0]   RPM_MIN_S = RPM_W'(64'd1 << (RPM_W - 1));
   localparam logic signed [KRAD_W:0]    KRAD_S   = (KRAD_W + 1)'(KRAD);
   localparam logic signed [KANG_W:0]    KANG_S   = (KANG_W + 1)'(KANG);
   localparam logic signed [SUM_W-1:0]   EMA_BIAS = SUM_W'((64'd1 << EMA_SHIFT) - 1);
   localparam logic signed [RAD_P_W-1:0] RAD_BIAS = RAD_P_W'((64'd1 << RAD_SHIFT) - 1);
   localparam logic signed [ANG_P_W-1:0] ANG_BIAS = ANG_P_W'((64'd1 << ANG_SHIFT) - 1);

   // configuration registers
   logic                        invert_ff;
   logic [DT_W-1:0]             min_int_ff;

   // captured transaction
   logic                        func_ff;
   logic [ANGLE_W-1:0]          raw_ff;
   logic [DT_W-1:0]             dt_ff;

   // tracking state
   logic [ANGLE_W-1:0]          last_angle_ff, last_angle_in;
   logic [ANGLE_W-1:0]          cur_angle_ff, cur_angle_in;
   logic                        have_ref_ff, have_ref_in;
   logic signed [DELTA_W-1:0]   delta_ff, delta_in;
   logic signed [TOTAL_W-1:0]   total_ff, total_in;
   logic signed [RPM_W-1:0]     sm_ff, sm_in;

   // divider and arithmetic working registers
   logic [NUM_W-1:0]            num_ff;
   logic [DT_W-1:0]             rem_ff;
   logic                        neg_ff;
   logic signed [RPM_W-1:0]     inst_ff, inst_in;
   logic signed [RAD_P_W-1:0]   rad_prod_ff;
   logic signed [ANG_P_W-1:0]   ang_prod_ff;

   // result register
   logic [ANGLE_W-1:0]          o_angle_ff;
   logic signed [DELTA_W-1:0]   o_delta_ff;
   logic signed [TOTAL_W-1:0]   o_total_ff;
   logic signed [RPM_W-1:0]     o_rpm_ff;
   logic signed [RAD_W-1:0]     o_rad_ff;
   logic signed [ANG_W-1:0]     o_ang_ff;
   logic                        o_primed_ff;

   // combinational helpers
   logic signed [DIFF_W-1:0]    diff, wrapped, stepped;
   logic [MAG_W-1:0]            mag;
   logic [DT_W:0]               rem_sh;
   logic                        qbit;
   logic [DT_W-1:0]             rem_next;
   logic signed [SUM_W-1:0]     ema_sum, ema_adj;
   logic signed [RAD_P_W-1:0]   rad_adj;
   logic signed [ANG_P_W-1:0]   ang_adj;
   logic signed [RAD_P_W-1:0]   rad_q;
   logic signed [ANG_P_W-1:0]   ang_q;

   // register writes, unknown indices dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff  <= 1'b0;
         min_int_ff <= MIN_INTERVAL_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_INVERT:       invert_ff  <= csr_data[0];
            CSR_MIN_INTERVAL: min_int_ff <= csr_data[DT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // capture the accepted sample
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         raw_ff  <= req_raw_angle;
         dt_ff   <= req_interval_us;
      end
   end

   // speed is only refreshed for a tracked sample with a long enough interval
   assign status.speed_go = !func_ff && have_ref_ff && (dt_ff > min_int_ff);

   // unwrap against the previous sample
   always_comb begin
      diff = $signed({2'b00, raw_ff}) - $signed({2'b00, last_angle_ff});
      if (diff > HALF_S) begin
         wrapped = diff - REV_S;
      end else if (diff < -HALF_S) begin
         wrapped = diff + REV_S;
      end else begin
         wrapped = diff;
      end
      stepped = invert_ff ? -wrapped : wrapped;
   end

   // tracking state update
   always_comb begin
      last_angle_in = last_angle_ff;
      cur_angle_in  = cur_angle_ff;
      have_ref_in   = have_ref_ff;
      delta_in      = delta_ff;
      total_in      = total_ff;
      if (cmd.update) begin
         if (func_ff) begin
            have_ref_in = 1'b0;
            delta_in    = '0;
            total_in    = '0;
         end else if (!have_ref_ff) begin
            last_angle_in = raw_ff;
            cur_angle_in  = raw_ff;
            have_ref_in   = 1'b1;
            delta_in      = '0;
         end else begin
            last_angle_in = raw_ff;
            cur_angle_in  = raw_ff;
            delta_in      = stepped[DELTA_W-1:0];
            total_in      = total_ff + TOTAL_W'(stepped);
         end
      end
   end

   // smoothing: weighted sum, divided by 256 rounding toward zero
   always_comb begin
      ema_sum = inst_ff * W_NEW + sm_ff * W_OLD;
      ema_adj = ema_sum + (ema_sum < 0 ? EMA_BIAS : '0);
      sm_in   = sm_ff;
      if (cmd.update && func_ff) begin
         sm_in = '0;
      end else if (cmd.smooth) begin
         sm_in = RPM_W'(ema_adj >>> EMA_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_angle_ff <= '0;
         cur_angle_ff  <= '0;
         have_ref_ff   <= 1'b0;
         delta_ff      <= '0;
         total_ff      <= '0;
         sm_ff         <= '0;
      end else begin
         last_angle_ff <= last_angle_in;
         cur_angle_ff  <= cur_angle_in;
         have_ref_ff   <= have_ref_in;
         delta_ff      <= delta_in;
         total_ff      <= total_in;
         sm_ff         <= sm_in;
      end
   end

   // restoring divider, one quotient bit per cycle
   assign mag      = delta_ff[DELTA_W-1] ? MAG_W'(-delta_ff) : MAG_W'(delta_ff);
   assign rem_sh   = {rem_ff, num_ff[NUM_W-1]};
   assign qbit     = rem_sh >= {1'b0, dt_ff};
   assign rem_next = qbit ? DT_W'(rem_sh - {1'b0, dt_ff}) : rem_sh[DT_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         num_ff <= NUM_W'(mag) * SCALE_C;
         rem_ff <= '0;
         neg_ff <= delta_ff[DELTA_W-1];
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[NUM_W-2:0], qbit};
         rem_ff <= rem_next;
      end
   end

   // signed and saturated instantaneous speed
   always_comb begin
      if (!neg_ff) begin
         inst_in = (num_ff > RPM_MAX_U) ? RPM_MAX_S : $signed(num_ff[RPM_W-1:0]);
      end else begin
         inst_in = (num_ff > RPM_MAX_U + NUM_W'(1)) ? RPM_MIN_S
                                                    : -$signed(num_ff[RPM_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.saturate) begin
         inst_ff <= inst_in;
      end
   end

   // output scaling products
   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         rad_prod_ff <= sm_ff * KRAD_S;
         ang_prod_ff <= total_ff * KANG_S;
      end
   end

   // shifts rounding toward zero
   assign rad_adj = rad_prod_ff + (rad_prod_ff < 0 ? RAD_BIAS : '0);
   assign ang_adj = ang_prod_ff + (ang_prod_ff < 0 ? ANG_BIAS : '0);
   assign rad_q   = rad_adj >>> RAD_SHIFT;
   assign ang_q   = ang_adj >>> ANG_SHIFT;

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         o_angle_ff  <= cur_angle_ff;
         o_delta_ff  <= delta_ff;
         o_total_ff  <= total_ff;
         o_rpm_ff    <= sm_ff;
         o_rad_ff    <= rad_q[RAD_W-1:0];
         o_ang_ff    <= ang_q[ANG_W-1:0];
         o_primed_ff <= have_ref_ff;
      end
   end

   assign rsp_angle_now     = o_angle_ff;
   assign rsp_delta_steps   = o_delta_ff;
   assign rsp_total_steps   = o_total_ff;
   assign rsp_speed_rpm_q8  = o_rpm_ff;
   assign rsp_speed_rad_q8  = o_rad_ff;
   assign rsp_angle_rad_q16 = o_ang_ff;
   assign rsp_primed        = o_primed_ff;

endmodule

`default_nettype wire

/* rtl/euv_checker.sv */
// ---------------------------------------------------------------------------
// euv_checker: port-level checks for the encoder unwrap block
// Watches the sample and result channels and flags sequencing slips.
// ---------------------------------------------------------------------------
`default_nettype none

module euv_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [euv_pkg::DELTA_W-1:0]  rsp_delta_steps,
   input wire logic signed [euv_pkg::TOTAL_W-1:0]  rsp_total_steps,
   input wire logic                                rsp_primed
);
   import euv_pkg::*;

   localparam logic signed [DELTA_W-1:0] HALF_D = DELTA_W'(HALF_TURN);

   // one sample in flight: no transaction in the cycle after one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample taken while previous one still in flight");

   // no result straight out of reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result keeps its total
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_steps))
      else $error("stalled result changed");

   // step change stays within half a turn
   a_delta_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_delta_steps >= -HALF_D) && (rsp_delta_steps <= HALF_D))
      else $error("step change outside half a turn");

   // unprimed results carry no motion
   a_unprimed_still: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_primed |-> rsp_delta_steps == '0)
      else $error("step change reported before priming");

endmodule

bind encoder_unwrap_velocity euv_checker u_euv_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_delta_steps (rsp_ch.delta_steps),
   .rsp_total_steps (rsp_ch.total_steps),
   .rsp_primed      (rsp_ch.primed)
);

`default_nettype wire

/* dv/tb_encoder_unwrap_velocity.sv */
// ---------------------------------------------------------------------------
// tb_encoder_unwrap_velocity: self-checking bench for the angle unwrap block
// Drives angle samples and clear commands through valid/ready channels,
// tracks the expected step total and smoothed speed in a scoreboard and
// compares every result transaction field by field. Register settings change
// between phases while the block is idle; both sides idle and stall at random.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_encoder_unwrap_velocity;
   import euv_pkg::*;

   // command codes and spare register slots
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_CLEAR  = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = CSR_IDX_W'(3);

   // speed and angle scaling, worked out independently of the design
   localparam longint RPM_PER_STEP_RATE = 64'sd3750000;
   localparam longint RAD_PER_RPM_Q32   = 64'sd449767923;
   localparam longint RAD_PER_STEP_Q32  = 64'sd6588397;
   localparam longint RPM_TOP           = 64'sd134217727;
   localparam longint RPM_FLOOR         = -64'sd134217728;
   localparam longint TURN_STEPS        = 64'sd4096;
   localparam longint HALF_TURN_STEPS   = 64'sd2048;
   localparam int     DT_TOP            = 1048575;

   // run control
   localparam int STALL_LIMIT    = 5000;
   localparam int HOLD_CYCLES    = 500;
   localparam int SETTLE_CYCLES  = 60;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 180;

   typedef struct {
      logic [ANGLE_W-1:0]        angle_now;
      logic signed [DELTA_W-1:0] delta_steps;
      logic signed [TOTAL_W-1:0] total_steps;
      logic signed [RPM_W-1:0]   speed_rpm_q8;
      logic signed [RAD_W-1:0]   speed_rad_q8;
      logic signed [ANG_W-1:0]   angle_rad_q16;
      logic                      primed;
   } motion_report_type;

   // tracker of angle, step total and smoothed speed, with pending reports
   class motion_scoreboard_type;
      bit              invert_on;
      bit [DT_W-1:0]   min_dt;
      bit [ANGLE_W-1:0] ref_angle;
      bit [ANGLE_W-1:0] shown_angle;
      bit              has_ref;
      longint          step_delta;
      bit [TOTAL_W-1:0] step_sum;
      longint          rpm_avg;
      motion_report_type expected_motion[$];
      int              errors;

      function new();
         invert_on   = 1'b0;
         min_dt      = MIN_INTERVAL_RST;
         ref_angle   = '0;
         shown_angle = '0;
         has_ref     = 1'b0;
         step_delta  = 0;
         step_sum    = '0;
         rpm_avg     = 0;
         errors      = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_INVERT:       invert_on = data[0];
            CSR_MIN_INTERVAL: min_dt    = data;
            default: ;
         endcase
      endfunction

      // advance the tracker by one accepted sample and queue the report
      function void track_sample(logic func, logic [ANGLE_W-1:0] raw, logic [DT_W-1:0] dt);
         longint d;
         longint inst;
         longint rad;
         longint ang;
         motion_report_type want;
         if (func == FUNC_CLEAR) begin
            step_sum   = '0;
            step_delta = 0;
            has_ref    = 1'b0;
            rpm_avg    = 0;
         end else if (!has_ref) begin
            ref_angle   = raw;
            shown_angle = raw;
            has_ref     = 1'b1;
            step_delta  = 0;
         end else begin
            d = longint'(raw) - longint'(ref_angle);
            if (d > HALF_TURN_STEPS) d -= TURN_STEPS;
            else if (d < -HALF_TURN_STEPS) d += TURN_STEPS;
            if (invert_on) d = -d;
            ref_angle   = raw;
            shown_angle = raw;
            step_delta  = d;
            step_sum    = step_sum + TOTAL_W'(d);
            // speed refresh only on a long enough interval
            if (dt > min_dt) begin
               inst = (d * RPM_PER_STEP_RATE) / longint'(dt);
               if (inst > RPM_TOP) inst = RPM_TOP;
               if (inst < RPM_FLOOR) inst = RPM_FLOOR;
               rpm_avg = (77 * inst + 179 * rpm_avg) / 256;
            end
         end
         rad = (rpm_avg * RAD_PER_RPM_Q32) / 64'sh1_0000_0000;
         ang = (longint'($signed(step_sum)) * RAD_PER_STEP_Q32) / 64'sd65536;
         want.angle_now     = shown_angle;
         want.delta_steps   = step_delta[DELTA_W-1:0];
         want.total_steps   = step_sum;
         want.speed_rpm_q8  = rpm_avg[RPM_W-1:0];
         want.speed_rad_q8  = rad[RAD_W-1:0];
         want.angle_rad_q16 = ang[ANG_W-1:0];
         want.primed        = has_ref;
         expected_motion.push_back(want);
      endfunction

      function void check_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(motion_report_type got);
         motion_report_type want;
         if (expected_motion.size() == 0) begin
            $error("result transaction with no sample outstanding");
            errors++;
            return;
         end
         want = expected_motion.pop_front();
         check_field("angle_now", want.angle_now, got.angle_now);
         check_field("delta_steps", want.delta_steps, got.delta_steps);
         check_field("total_steps", want.total_steps, got.total_steps);
         check_field("speed_rpm_q8", want.speed_rpm_q8, got.speed_rpm_q8);
         check_field("speed_rad_q8", want.speed_rad_q8, got.speed_rad_q8);
         check_field("angle_rad_q16", want.angle_rad_q16, got.angle_rad_q16);
         check_field("primed", want.primed, got.primed);
      endfunction

      function int pending();
         return expected_motion.size();
      endfunction

      function void flag_leftovers();
         if (expected_motion.size() != 0) begin
            $error("%0d results never arrived", expected_motion.size());
            errors += expected_motion.size();
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;

   euv_req_if req_bus ();
   euv_rsp_if rsp_bus ();
   euv_csr_if csr_bus ();

   encoder_unwrap_velocity dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   motion_scoreboard_type sb = new();

   bit               hold_pending = 1'b0;
   int               burst_left   = 0;
   logic [ANGLE_W-1:0] aim_angle  = '0;
   int               idle_cycles  = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // monitor: register writes, accepted samples and results
   always @(posedge clock) begin
      motion_report_type got;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            sb.write_register(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready)
            sb.track_sample(req_bus.func, req_bus.raw_angle, req_bus.interval_us);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.angle_now     = rsp_bus.angle_now;
            got.delta_steps   = rsp_bus.delta_steps;
            got.total_steps   = rsp_bus.total_steps;
            got.speed_rpm_q8  = rsp_bus.speed_rpm_q8;
            got.speed_rad_q8  = rsp_bus.speed_rad_q8;
            got.angle_rad_q16 = rsp_bus.angle_rad_q16;
            got.primed        = rsp_bus.primed;
            sb.check_result(got);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: stall patterns in segments, plus one long hold-off on request
   initial begin
      int seg_len;
      int mode;
      logic r;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         seg_len = $urandom_range(20, 200);
         mode    = $urandom_range(0, 3);
         for (int i = 0; i < seg_len; i++) begin
            if (hold_pending) begin
               for (int h = 0; h < HOLD_CYCLES; h++) begin
                  rsp_bus.ready <= 1'b0;
                  @(posedge clock);
               end
               hold_pending = 1'b0;
            end
            case (mode)
               0:       r = 1'b1;
               1:       r = 1'($urandom_range(0, 1));
               2:       r = (i % 4 == 3);
               default: r = ((i / 6) % 2 == 0);
            endcase
            rsp_bus.ready <= r;
            @(posedge clock);
         end
      end
   end

   // one sample transaction, with burst and gap handling in front of it
   task automatic send_sample(logic func, logic [ANGLE_W-1:0] raw, logic [DT_W-1:0] dt);
      int gap;
      if (burst_left == 0) begin
         if (!hold_pending && $urandom_range(0, 3) != 0) begin
            req_bus.valid <= 1'b0;
            gap = $urandom_range(1, 20);
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.func        <= func;
      req_bus.raw_angle   <= raw;
      req_bus.interval_us <= dt;
      if (func == FUNC_SAMPLE) aim_angle = raw;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // wait until every outstanding result has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      // let the monitor note the last accepted sample before polling
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // register writes back to back, spare slot optionally poked
   task automatic program_registers(bit inv, logic [DT_W-1:0] min_interval, bit poke_spare);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_INVERT;
      csr_bus.data  <= {CSR_DATA_W'($urandom) & ~CSR_DATA_W'(1)} | CSR_DATA_W'(inv);
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.index <= CSR_MIN_INTERVAL;
      csr_bus.data  <= min_interval;
      do @(posedge clock); while (!csr_bus.ready);
      if (poke_spare) begin
         csr_bus.index <= ($urandom_range(0, 1) != 0) ? CSR_SPARE_A : CSR_SPARE_B;
         csr_bus.data  <= CSR_DATA_W'($urandom);
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
   endtask

   // mostly plausible motion with random interval, occasional clears
   task automatic send_random(logic [DT_W-1:0] min_interval);
      int pick;
      int step;
      int dt;
      logic [ANGLE_W-1:0] raw;
      if ($urandom_range(0, 99) < 3) begin
         send_sample(FUNC_CLEAR, ANGLE_W'($urandom), DT_W'($urandom));
         return;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50)      step = $urandom_range(0, 128) - 64;
      else if (pick < 65) step = $urandom_range(0, 1200) - 600;
      else if (pick < 80) step = $urandom_range(0, 4095);
      else if (pick < 85) step = ($urandom_range(0, 1) != 0) ? 2048 : -2048;
      else if (pick < 90) step = 0;
      else                step = ($urandom_range(0, 1) != 0) ? $urandom_range(2040, 2047)
                                                             : -$urandom_range(2040, 2047);
      raw = aim_angle + ANGLE_W'(step);
      pick = $urandom_range(0, 99);
      if (pick < 40)      dt = $urandom_range(0, 3000);
      else if (pick < 55) dt = int'(min_interval) + $urandom_range(0, 2) - 1;
      else if (pick < 70) dt = $urandom_range(0, 60);
      else if (pick < 85) dt = $urandom_range(0, DT_TOP);
      else                dt = $urandom_range(1000, 100000);
      if (dt < 0) dt = 0;
      if (dt > DT_TOP) dt = DT_TOP;
      send_sample(FUNC_SAMPLE, raw, DT_W'(dt));
   endtask

   // stimulus
   initial begin
      bit [DT_W-1:0] min_choice;
      req_bus.valid       <= 1'b0;
      req_bus.func        <= FUNC_SAMPLE;
      req_bus.raw_angle   <= '0;
      req_bus.interval_us <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= CSR_INVERT;
      csr_bus.data        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, register values as left by reset
      send_sample(FUNC_SAMPLE, 12'd0, 20'd0);
      send_sample(FUNC_SAMPLE, 12'd4095, 20'd1048575);
      send_sample(FUNC_SAMPLE, 12'd2047, 20'd101);
      send_sample(FUNC_SAMPLE, 12'd4095, 20'd100);
      send_sample(FUNC_SAMPLE, 12'd0, 20'd1);
      send_sample(FUNC_CLEAR, 12'd4095, 20'd1048575);
      send_sample(FUNC_CLEAR, 12'd0, 20'd0);
      send_sample(FUNC_SAMPLE, 12'd2048, 20'd5000);
      send_sample(FUNC_SAMPLE, 12'd0, 20'd200);
      send_sample(FUNC_SAMPLE, 12'd2048, 20'd0);
      drain();

      // directed, inverted with no minimum interval: negative saturation
      program_registers(1'b1, 20'd0, 1'b1);
      send_sample(FUNC_SAMPLE, 12'd100, 20'd1);
      send_sample(FUNC_SAMPLE, 12'd2148, 20'd1);
      send_sample(FUNC_SAMPLE, 12'd2148, 20'd0);
      send_sample(FUNC_SAMPLE, 12'd1, 20'd57);
      send_sample(FUNC_CLEAR, 12'd0, 20'd0);
      send_sample(FUNC_SAMPLE, 12'd4095, 20'd3);
      send_sample(FUNC_SAMPLE, 12'd0, 20'd2);
      drain();

      // random phases over a spread of register settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       min_choice = 20'd0;
            1:       min_choice = 20'd1048575;
            2:       min_choice = DT_W'($urandom_range(0, 200));
            3:       min_choice = MIN_INTERVAL_RST;
            4:       min_choice = DT_W'($urandom_range(0, DT_TOP));
            default: min_choice = DT_W'($urandom_range(20, 60));
         endcase
         program_registers(bit'(p % 2) ^ bit'(p / 4), min_choice,
                           1'($urandom_range(0, 1)));
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 2 && k == 60) hold_pending = 1'b1;
            send_random(min_choice);
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.flag_leftovers();
      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
